### hdl/mie_pkg.sv
// shared types, constants and lookup functions for the image encoder
package mie_pkg;

    localparam int MAX_ROW_WORDS_DEF = 1024;
    localparam int HIST_ROWS         = 17;

    localparam logic [11:0] WIDTH_RST  = 12'd640;
    localparam logic [16:0] HEIGHT_RST = 17'd400;
    localparam logic        COLOR_RST  = 1'b0;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_COLOR  = 2'd2;

    localparam logic [1:0] STREAM_A = 2'd0;
    localparam logic [1:0] STREAM_B = 2'd1;
    localparam logic [1:0] STREAM_P = 2'd2;

    localparam logic [3:0] LAST_TRY = 4'd15;

    typedef struct packed {
        logic [11:0] width;
        logic [16:0] height;
        logic        color;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  stream;
        logic [15:0] value;
        logic        done;
    } res_t;

    typedef struct packed {
        logic push;
        logic close;
        res_t res;
    } out_req_t;

    typedef struct packed {
        logic can_push;
        logic can_close;
    } out_sts_t;

    function automatic logic [3:0] try_code(input logic [3:0] t);
        logic [3:0] c;
        unique case (t)
            4'd0:    c = 4'd1;
            4'd1:    c = 4'd4;
            4'd2:    c = 4'd5;
            4'd3:    c = 4'd6;
            4'd4:    c = 4'd7;
            4'd5:    c = 4'd9;
            4'd6:    c = 4'd10;
            4'd7:    c = 4'd2;
            4'd8:    c = 4'd8;
            4'd9:    c = 4'd11;
            4'd10:   c = 4'd12;
            4'd11:   c = 4'd13;
            4'd12:   c = 4'd14;
            4'd13:   c = 4'd3;
            4'd14:   c = 4'd15;
            default: c = 4'd0;
        endcase
        return c;
    endfunction

    function automatic logic [2:0] off_dx(input logic [3:0] c);
        logic [2:0] d;
        unique case (c)
            4'd1, 4'd5, 4'd7, 4'd10, 4'd13: d = 3'd1;
            4'd2, 4'd8, 4'd11, 4'd14:       d = 3'd2;
            4'd3:                           d = 3'd4;
            default:                        d = 3'd0;
        endcase
        return d;
    endfunction

    function automatic logic [4:0] off_dy(input logic [3:0] c);
        logic [4:0] d;
        unique case (c)
            4'd4, 4'd5:             d = 5'd1;
            4'd6, 4'd7, 4'd8:       d = 5'd2;
            4'd9, 4'd10, 4'd11:     d = 5'd4;
            4'd12, 4'd13, 4'd14:    d = 5'd8;
            4'd15:                  d = 5'd16;
            default:                d = 5'd0;
        endcase
        return d;
    endfunction

    function automatic logic [3:0] nib_shift(input logic [1:0] pos);
        logic [3:0] s;
        unique case (pos)
            2'd0:    s = 4'd4;
            2'd1:    s = 4'd0;
            2'd2:    s = 4'd12;
            default: s = 4'd8;
        endcase
        return s;
    endfunction

endpackage

### hdl/mie_ram.sv
// generic simple dual-port ram with registered read
module mie_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hdl/mie_out.sv
// result hold stage and output register, marks the last word of each dot
module mie_out
    import mie_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  out_req_t    req,
    output out_sts_t    sts,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,
    output logic        m_tlast,
    output logic [2:0]  m_tuser
);

    logic hold_v_reg, hold_v_next;
    res_t hold_reg, hold_next;
    logic out_v_reg, out_v_next;
    res_t out_reg, out_next;
    logic last_reg, last_next;
    logic out_free;

    assign out_free = !out_v_reg || m_tready;
    assign sts.can_push  = !hold_v_reg || out_free;
    assign sts.can_close = !hold_v_reg || out_free;

    always_comb
    begin
        hold_v_next = hold_v_reg;
        hold_next   = hold_reg;
        out_v_next  = out_v_reg;
        out_next    = out_reg;
        last_next   = last_reg;
        if (out_v_reg && m_tready)
        begin
            out_v_next = 1'b0;
        end
        if (req.push)
        begin
            if (hold_v_reg)
            begin
                out_v_next = 1'b1;
                out_next   = hold_reg;
                last_next  = 1'b0;
            end
            hold_v_next = 1'b1;
            hold_next   = req.res;
        end
        else if (req.close && hold_v_reg)
        begin
            out_v_next  = 1'b1;
            out_next    = hold_reg;
            last_next   = 1'b1;
            hold_v_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_v_reg <= 1'b0;
            hold_reg   <= '0;
            out_v_reg  <= 1'b0;
            out_reg    <= '0;
            last_reg   <= 1'b0;
        end
        else
        begin
            hold_v_reg <= hold_v_next;
            hold_reg   <= hold_next;
            out_v_reg  <= out_v_next;
            out_reg    <= out_next;
            last_reg   <= last_next;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_reg.value;
    assign m_tlast  = last_reg;
    assign m_tuser  = {out_reg.done, out_reg.stream};

    property p_push_room;
        @(posedge clk) disable iff (!rst_n) req.push |-> sts.can_push;
    endproperty
    a_push_room: assert property (p_push_room) else $error("push without room");

    property p_hold_kept;
        @(posedge clk) disable iff (!rst_n)
            (hold_v_reg && !req.push && !req.close) |=> hold_v_reg;
    endproperty
    a_hold_kept: assert property (p_hold_kept) else $error("held result lost");

    property p_close_empties;
        @(posedge clk) disable iff (!rst_n)
            (req.close && !req.push && sts.can_close) |=> !hold_v_reg;
    endproperty
    a_close_empties: assert property (p_close_empties) else $error("close left a result");

endmodule

### hdl/mie_ctrl.sv
// word packing, history search, flag byte and a/b stream sequencer
module mie_ctrl
    import mie_pkg::*;
#(
    parameter int MAX_ROW_WORDS = MAX_ROW_WORDS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       restart,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] dot,
    output out_req_t   out_req,
    input  out_sts_t   out_sts
);

    localparam int HDEPTH = HIST_ROWS * MAX_ROW_WORDS;
    localparam int HW     = $clog2(HDEPTH);
    localparam int WCW    = $clog2(MAX_ROW_WORDS + 1);
    localparam int FDEPTH = (MAX_ROW_WORDS + 1) / 2;
    localparam int FW     = $clog2(FDEPTH);
    localparam int LIM16  = (MAX_ROW_WORDS / 2) * 8;
    localparam int LIM256 = (MAX_ROW_WORDS / 4) * 8;

    typedef enum logic [11:0] {
        ST_IDLE  = 12'b000000000001,
        ST_ADV   = 12'b000000000010,
        ST_SRCH  = 12'b000000000100,
        ST_WR    = 12'b000000001000,
        ST_EMITP = 12'b000000010000,
        ST_FLAG  = 12'b000000100000,
        ST_EMITA = 12'b000001000000,
        ST_NEXTW = 12'b000010000000,
        ST_FA    = 12'b000100000000,
        ST_FA2   = 12'b001000000000,
        ST_FB    = 12'b010000000000,
        ST_LAST  = 12'b100000000000
    } state_t;

    state_t          state_reg, state_next;
    logic [15:0]     acc_reg, acc_next;
    logic [3:0]      nib_reg, nib_next;
    logic [11:0]     dc_reg, dc_next;
    logic [WCW-1:0]  wc_reg, wc_next;
    logic [16:0]     row_reg, row_next;
    logic [4:0]      slot_reg, slot_next;
    logic [7:0]      ab_reg, ab_next;
    logic [2:0]      apos_reg, apos_next;
    logic            aodd_reg, aodd_next;
    logic            bodd_reg, bodd_next;
    logic            rowend_reg, rowend_next;
    logic [3:0]      try_reg, try_next;
    logic            pv_reg, pv_next;
    logic [3:0]      pcode_reg, pcode_next;
    logic [3:0]      code_reg, code_next;

    logic [15:0]     hist_rdata;
    logic [HW-1:0]   hist_raddr, hist_waddr;
    logic            hist_we;
    logic [7:0]      flag_rdata;
    logic            flag_we;
    logic [FW-1:0]   flag_addr;

    logic [15:0]     ew;
    logic [15:0]     w1;
    logic [16:0]     eh;
    logic [3:0]      c;
    logic [2:0]      dx;
    logic [4:0]      dy;
    logic [5:0]      sd;
    logic            try_ok;
    logic [7:0]      fbyte, xbyte;
    logic [1:0]      pos;
    logic            word_end;
    logic [15:0]     ins;
    logic [12:0]     dc_inc;

    assign w1 = (cfg.width == 12'd0) ? 16'd1 : {4'd0, cfg.width};
    assign eh = (cfg.height == 17'd0) ? 17'd1 : cfg.height;

    always_comb
    begin
        if (cfg.color)
        begin
            ew = (w1 > 16'(LIM256)) ? 16'(LIM256) : w1;
        end
        else
        begin
            ew = (w1 > 16'(LIM16)) ? 16'(LIM16) : w1;
        end
    end

    assign c      = try_code(try_reg);
    assign dx     = off_dx(c);
    assign dy     = off_dy(c);
    assign try_ok = (WCW'(dx) <= wc_reg) && ({12'd0, dy} <= row_reg);

    always_comb
    begin
        sd = {1'b0, slot_reg} - {1'b0, dy};
        if (slot_reg < dy)
        begin
            sd = sd + 6'(HIST_ROWS);
        end
    end

    assign hist_raddr = HW'(sd[4:0]) * HW'(MAX_ROW_WORDS) + HW'(wc_reg - WCW'(dx));
    assign hist_waddr = HW'(slot_reg) * HW'(MAX_ROW_WORDS) + HW'(wc_reg);
    assign flag_addr  = FW'(wc_reg >> 1);
    assign fbyte      = {nib_reg, code_reg};
    assign xbyte      = (row_reg != 17'd0) ? (fbyte ^ flag_rdata) : fbyte;

    assign pos      = cfg.color ? {1'b0, dc_reg[0]} : dc_reg[1:0];
    assign word_end = cfg.color ? dc_reg[0] : (dc_reg[1:0] == 2'd3);
    assign dc_inc   = {1'b0, dc_reg} + 13'd1;

    always_comb
    begin
        if (cfg.color)
        begin
            ins = pos[0] ? {dot, 8'd0} : {8'd0, dot};
        end
        else
        begin
            ins = {12'd0, dot[3:0]} << nib_shift(pos);
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        acc_next    = acc_reg;
        nib_next    = nib_reg;
        dc_next     = dc_reg;
        wc_next     = wc_reg;
        row_next    = row_reg;
        slot_next   = slot_reg;
        ab_next     = ab_reg;
        apos_next   = apos_reg;
        aodd_next   = aodd_reg;
        bodd_next   = bodd_reg;
        rowend_next = rowend_reg;
        try_next    = try_reg;
        pv_next     = pv_reg;
        pcode_next  = pcode_reg;
        code_next   = code_reg;
        hist_we     = 1'b0;
        flag_we     = 1'b0;
        out_req     = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_valid)
                begin
                    acc_next    = acc_reg | ins;
                    dc_next     = dc_inc[11:0];
                    rowend_next = ({3'd0, dc_inc} >= ew);
                    try_next    = 4'd0;
                    pv_next     = 1'b0;
                    state_next  = word_end ? ST_SRCH : ST_ADV;
                end
            end
            ST_ADV:
            begin
                if (!rowend_reg)
                begin
                    state_next = ST_LAST;
                end
                else if (dc_reg[2:0] != 3'd0)
                begin
                    dc_next    = dc_inc[11:0];
                    try_next   = 4'd0;
                    pv_next    = 1'b0;
                    state_next = word_end ? ST_SRCH : ST_ADV;
                end
                else
                begin
                    dc_next     = 12'd0;
                    wc_next     = '0;
                    acc_next    = 16'd0;
                    rowend_next = 1'b0;
                    row_next    = row_reg + 17'd1;
                    slot_next   = (slot_reg == 5'(HIST_ROWS - 1)) ? 5'd0 : slot_reg + 5'd1;
                    state_next  = ({1'b0, row_reg} + 18'd1 >= {1'b0, eh}) ? ST_FA : ST_LAST;
                end
            end
            ST_SRCH:
            begin
                if (pv_reg && (hist_rdata == acc_reg))
                begin
                    code_next  = pcode_reg;
                    pv_next    = 1'b0;
                    state_next = ST_WR;
                end
                else if (try_reg == LAST_TRY)
                begin
                    pv_next = 1'b0;
                    if (!pv_reg)
                    begin
                        code_next  = 4'd0;
                        state_next = ST_WR;
                    end
                end
                else
                begin
                    pv_next    = try_ok;
                    pcode_next = c;
                    try_next   = try_reg + 4'd1;
                end
            end
            ST_WR:
            begin
                hist_we    = 1'b1;
                state_next = ST_EMITP;
            end
            ST_EMITP:
            begin
                if ((code_reg != 4'd0) || out_sts.can_push)
                begin
                    if (code_reg == 4'd0)
                    begin
                        out_req.push       = 1'b1;
                        out_req.res.stream = STREAM_P;
                        out_req.res.value  = acc_reg;
                    end
                    if (wc_reg[0])
                    begin
                        state_next = ST_FLAG;
                    end
                    else
                    begin
                        nib_next   = code_reg;
                        state_next = ST_NEXTW;
                    end
                end
            end
            ST_FLAG:
            begin
                if ((xbyte == 8'd0) || out_sts.can_push)
                begin
                    flag_we = 1'b1;
                    if (xbyte != 8'd0)
                    begin
                        out_req.push       = 1'b1;
                        out_req.res.stream = STREAM_B;
                        out_req.res.value  = {8'd0, xbyte};
                        bodd_next          = ~bodd_reg;
                        ab_next            = ab_reg | (8'h80 >> apos_reg);
                    end
                    apos_next  = apos_reg + 3'd1;
                    state_next = (apos_reg == 3'd7) ? ST_EMITA : ST_NEXTW;
                end
            end
            ST_EMITA:
            begin
                if (out_sts.can_push)
                begin
                    out_req.push       = 1'b1;
                    out_req.res.stream = STREAM_A;
                    out_req.res.value  = {8'd0, ab_reg};
                    aodd_next          = ~aodd_reg;
                    ab_next            = 8'd0;
                    state_next         = ST_NEXTW;
                end
            end
            ST_NEXTW:
            begin
                wc_next    = wc_reg + WCW'(1);
                acc_next   = 16'd0;
                state_next = ST_ADV;
            end
            ST_FA:
            begin
                if (apos_reg == 3'd0)
                begin
                    state_next = ST_FA2;
                end
                else if (out_sts.can_push)
                begin
                    out_req.push       = 1'b1;
                    out_req.res.stream = STREAM_A;
                    out_req.res.value  = {8'd0, ab_reg};
                    out_req.res.done   = 1'b1;
                    aodd_next          = ~aodd_reg;
                    state_next         = ST_FA2;
                end
            end
            ST_FA2:
            begin
                if (!aodd_reg)
                begin
                    state_next = ST_FB;
                end
                else if (out_sts.can_push)
                begin
                    out_req.push       = 1'b1;
                    out_req.res.stream = STREAM_A;
                    out_req.res.done   = 1'b1;
                    state_next         = ST_FB;
                end
            end
            ST_FB:
            begin
                if (!bodd_reg || out_sts.can_push)
                begin
                    if (bodd_reg)
                    begin
                        out_req.push       = 1'b1;
                        out_req.res.stream = STREAM_B;
                        out_req.res.done   = 1'b1;
                    end
                    nib_next   = 4'd0;
                    row_next   = 17'd0;
                    slot_next  = 5'd0;
                    ab_next    = 8'd0;
                    apos_next  = 3'd0;
                    aodd_next  = 1'b0;
                    bodd_next  = 1'b0;
                    state_next = ST_LAST;
                end
            end
            ST_LAST:
            begin
                if (out_sts.can_close)
                begin
                    out_req.close = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (restart)
        begin
            acc_next    = 16'd0;
            nib_next    = 4'd0;
            dc_next     = 12'd0;
            wc_next     = '0;
            row_next    = 17'd0;
            slot_next   = 5'd0;
            ab_next     = 8'd0;
            apos_next   = 3'd0;
            aodd_next   = 1'b0;
            bodd_next   = 1'b0;
            rowend_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            acc_reg    <= 16'd0;
            nib_reg    <= 4'd0;
            dc_reg     <= 12'd0;
            wc_reg     <= '0;
            row_reg    <= 17'd0;
            slot_reg   <= 5'd0;
            ab_reg     <= 8'd0;
            apos_reg   <= 3'd0;
            aodd_reg   <= 1'b0;
            bodd_reg   <= 1'b0;
            rowend_reg <= 1'b0;
            try_reg    <= 4'd0;
            pv_reg     <= 1'b0;
            pcode_reg  <= 4'd0;
            code_reg   <= 4'd0;
        end
        else
        begin
            state_reg  <= state_next;
            acc_reg    <= acc_next;
            nib_reg    <= nib_next;
            dc_reg     <= dc_next;
            wc_reg     <= wc_next;
            row_reg    <= row_next;
            slot_reg   <= slot_next;
            ab_reg     <= ab_next;
            apos_reg   <= apos_next;
            aodd_reg   <= aodd_next;
            bodd_reg   <= bodd_next;
            rowend_reg <= rowend_next;
            try_reg    <= try_next;
            pv_reg     <= pv_next;
            pcode_reg  <= pcode_next;
            code_reg   <= code_next;
        end
    end

    mie_ram #(
        .WIDTH (16),
        .DEPTH (HDEPTH)
    ) u_hist (
        .clk   (clk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (acc_reg),
        .raddr (hist_raddr),
        .rdata (hist_rdata)
    );

    mie_ram #(
        .WIDTH (8),
        .DEPTH (FDEPTH)
    ) u_flag (
        .clk   (clk),
        .we    (flag_we),
        .waddr (flag_addr),
        .wdata (fbyte),
        .raddr (flag_addr),
        .rdata (flag_rdata)
    );

    property p_wc_range;
        @(posedge clk) disable iff (!rst_n) wc_reg <= WCW'(MAX_ROW_WORDS);
    endproperty
    a_wc_range: assert property (p_wc_range) else $error("word column overrun");

    property p_flag_odd;
        @(posedge clk) disable iff (!rst_n) flag_we |-> wc_reg[0];
    endproperty
    a_flag_odd: assert property (p_flag_odd) else $error("flag byte on even column");

    property p_slot_range;
        @(posedge clk) disable iff (!rst_n) slot_reg < 5'(HIST_ROWS);
    endproperty
    a_slot_range: assert property (p_slot_range) else $error("history slot overrun");

    property p_flush_clears;
        @(posedge clk) disable iff (!rst_n)
            (state_reg == ST_FB && state_next == ST_LAST) |=>
                (row_reg == 17'd0 && apos_reg == 3'd0 && !aodd_reg && !bodd_reg);
    endproperty
    a_flush_clears: assert property (p_flush_clears) else $error("flush left state");

endmodule

### hdl/mag_image_encoder_core.sv
// top level: register port, encoder sequencer and output stage
//
//  channel   dir  payload                               handshake
//  s_axis    in   tdata[7:0] dot                        tvalid/tready
//  m_axis    out  tdata value, tuser stream+done, tlast tvalid/tready
//  apb       in   width, height, color_mode             psel/penable, pready high
//
//  a dot that completes no word passes accept, advance and close; a completed
//  word adds the history search (one read per try, one more when the last try
//  misses), history write, p word, flag byte, a byte and column step; row end
//  adds the padding words, image end flushes the open a byte and the a and b
//  padding words; reset leaves history and flag memories unwritten, no clearing
//  pass; a stalled output holds the sequencer only to push a word or close a dot
module mag_image_encoder_core
    import mie_pkg::*;
#(
    parameter int MAX_ROW_WORDS = MAX_ROW_WORDS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // dot
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // value
    output logic        m_axis_tlast,
    output logic [2:0]  m_axis_tuser    // stream[1:0], image_done[2]
);

    cfg_t       cfg_reg, cfg_next;
    logic       wr_en;
    logic       restart;
    logic [1:0] reg_idx;
    out_req_t   out_req;
    out_sts_t   out_sts;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        restart  = 1'b0;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_WIDTH:
                begin
                    cfg_next.width = pwdata[11:0];
                    restart        = 1'b1;
                end
                REG_HEIGHT:
                begin
                    cfg_next.height = pwdata[16:0];
                    restart         = 1'b1;
                end
                REG_COLOR:
                begin
                    cfg_next.color = pwdata[0];
                    restart        = 1'b1;
                end
                default:
                begin
                    restart = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_WIDTH:  prdata = {20'd0, cfg_reg.width};
            REG_HEIGHT: prdata = {15'd0, cfg_reg.height};
            REG_COLOR:  prdata = {31'd0, cfg_reg.color};
            default:    prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.width  <= WIDTH_RST;
            cfg_reg.height <= HEIGHT_RST;
            cfg_reg.color  <= COLOR_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    mie_ctrl #(
        .MAX_ROW_WORDS (MAX_ROW_WORDS)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .restart (restart),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .dot     (s_axis_tdata),
        .out_req (out_req),
        .out_sts (out_sts)
    );

    mie_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (out_req),
        .sts      (out_sts),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .m_tdata  (m_axis_tdata),
        .m_tlast  (m_axis_tlast),
        .m_tuser  (m_axis_tuser)
    );

endmodule

### tb/mag_image_encoder_core_tb.sv
// self-checking testbench for mag_image_encoder_core with a scoreboard class
module mag_image_encoder_core_tb;
    import mie_pkg::*;

    localparam int ROW_WORDS = 1024;
    localparam int HROWS     = 17;
    localparam int WATCH_LIM = 20000;
    localparam int SETTLE    = 400;

    typedef struct {
        logic [1:0]  stream;
        logic [15:0] value;
        logic        last;
        logic        done;
    } enc_word_t;

    class enc_scoreboard;
        int unsigned width, height, color;
        logic [15:0] hist [HROWS*ROW_WORDS];
        logic [7:0]  prev_flags [ROW_WORDS/2+1];
        logic [15:0] acc;
        logic [3:0]  pend;
        int unsigned dcol, wcol, rowc, slot;
        logic [7:0]  abyte;
        int unsigned apos;
        bit          aodd, bodd;
        enc_word_t   pending_words [$];
        enc_word_t   step_words [$];
        int          errors;

        function new();
            width = 640;
            height = 400;
            color = 0;
            errors = 0;
            foreach (hist[i]) hist[i] = '0;
            foreach (prev_flags[i]) prev_flags[i] = '0;
            restart();
        endfunction

        function void restart();
            acc = '0;
            pend = '0;
            dcol = 0;
            wcol = 0;
            rowc = 0;
            slot = 0;
            abyte = '0;
            apos = 0;
            aodd = 0;
            bodd = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] v);
            if (idx == REG_WIDTH) width = v[11:0];
            else if (idx == REG_HEIGHT) height = v[16:0];
            else if (idx == REG_COLOR) color = v[0];
            restart();
        endfunction

        function void push_word(logic [1:0] s, logic [15:0] v, logic d);
            enc_word_t e;
            e.stream = s;
            e.value = v;
            e.last = 1'b0;
            e.done = d;
            step_words.push_back(e);
        endfunction

        function void code_word(logic [15:0] w);
            int unsigned tries [15] = '{1, 4, 5, 6, 7, 9, 10, 2, 8, 11, 12, 13, 14, 3, 15};
            int unsigned dxs [16] = '{0, 1, 2, 4, 0, 1, 0, 1, 2, 0, 1, 2, 0, 1, 2, 0};
            int unsigned dys [16] = '{0, 0, 0, 0, 1, 1, 2, 2, 2, 4, 4, 4, 8, 8, 8, 16};
            int unsigned code, c, s;
            logic [7:0] fbyte, x;
            code = 0;
            if (wcol >= ROW_WORDS) return;
            for (int t = 0; t < 15; t++)
            begin
                c = tries[t];
                if (code == 0 && dxs[c] <= wcol && dys[c] <= rowc)
                begin
                    s = (slot + HROWS - dys[c]) % HROWS;
                    if (hist[s*ROW_WORDS + wcol - dxs[c]] == w) code = c;
                end
            end
            hist[slot*ROW_WORDS + wcol] = w;
            if (code == 0) push_word(STREAM_P, w, 1'b0);
            if (wcol[0] == 1'b0)
                pend = code[3:0];
            else
            begin
                fbyte = {pend, code[3:0]};
                x = (rowc != 0) ? (fbyte ^ prev_flags[wcol >> 1]) : fbyte;
                prev_flags[wcol >> 1] = fbyte;
                if (x != 0)
                begin
                    push_word(STREAM_B, {8'h00, x}, 1'b0);
                    bodd = !bodd;
                    abyte = abyte | (8'h80 >> apos);
                end
                apos++;
                if (apos == 8)
                begin
                    push_word(STREAM_A, {8'h00, abyte}, 1'b0);
                    aodd = !aodd;
                    abyte = '0;
                    apos = 0;
                end
            end
            wcol++;
        endfunction

        function void next_dot(int unsigned per);
            int unsigned pos;
            pos = dcol & (per - 1);
            dcol++;
            if (pos == per - 1)
            begin
                code_word(acc);
                acc = '0;
            end
        endfunction

        // note an accepted dot and queue the words it causes
        function void note_dot(logic [7:0] d);
            int unsigned shifts [4] = '{4, 0, 12, 8};
            int unsigned per, ew, eh, pos, lim;
            per = color ? 2 : 4;
            lim = color ? 2048 : 4096;
            ew = (width == 0) ? 1 : width;
            if (ew > lim) ew = lim;
            eh = (height == 0) ? 1 : height;
            pos = dcol & (per - 1);
            step_words.delete();
            if (color) acc = acc | (16'(d) << (pos ? 8 : 0));
            else acc = acc | (16'(d[3:0]) << shifts[pos]);
            next_dot(per);
            if (dcol >= ew)
            begin
                while ((dcol & 7) != 0) next_dot(per);
                dcol = 0;
                wcol = 0;
                acc = '0;
                rowc++;
                slot = (slot + 1) % HROWS;
                if (rowc >= eh)
                begin
                    if (apos > 0)
                    begin
                        push_word(STREAM_A, {8'h00, abyte}, 1'b1);
                        aodd = !aodd;
                    end
                    if (aodd) push_word(STREAM_A, 16'h0000, 1'b1);
                    if (bodd) push_word(STREAM_B, 16'h0000, 1'b1);
                    restart();
                end
            end
            if (step_words.size() > 0) step_words[step_words.size()-1].last = 1'b1;
            foreach (step_words[i]) pending_words.push_back(step_words[i]);
        endfunction

        task report(string what);
            $display("mismatch: %s", what);
            errors++;
        endtask

        task check_word(logic [15:0] v, logic [2:0] u, logic l);
            enc_word_t e;
            if (pending_words.size() == 0)
            begin
                report($sformatf("unexpected word value=%h user=%h", v, u));
                return;
            end
            e = pending_words.pop_front();
            if (u[1:0] !== e.stream)
                report($sformatf("stream got %0d want %0d", u[1:0], e.stream));
            if (v !== e.value)
                report($sformatf("value got %h want %h", v, e.value));
            if (l !== e.last)
                report($sformatf("tlast got %b want %b", l, e.last));
            if (u[2] !== e.done)
                report($sformatf("image_done got %b want %b", u[2], e.done));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;   // dot
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;        // value
    logic        m_axis_tlast;
    logic [2:0]  m_axis_tuser;        // stream[1:0], image_done[2]

    enc_scoreboard sb = new();
    int unsigned   tx_idle = 0;
    int unsigned   rx_idle = 0;
    int unsigned   stall_cycles = 0;
    logic [7:0]    tone_a, tone_b, last_dot;

    mag_image_encoder_core dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .m_axis_tuser(m_axis_tuser)
    );

    always #5 clk = ~clk;

    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= rx_idle);

    always @(posedge clk)
        if (m_axis_tvalid && m_axis_tready)
            sb.check_word(m_axis_tdata, m_axis_tuser, m_axis_tlast);

    always @(posedge clk)
    begin
        if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)
            || !(s_axis_tvalid || sb.pending_words.size() > 0))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WATCH_LIM)
        begin
            $display("timeout waiting for a handshake");
            $display("mag_image_encoder_core regression: fail");
            $finish;
        end
    end

    task reg_write(logic [1:0] idx, logic [31:0] v);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 4'(idx) << 2;
        pwdata <= v;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.set_reg(idx, v);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task drain();
        wait (sb.pending_words.size() == 0);
        repeat (SETTLE) @(negedge clk);
    endtask

    task configure(int unsigned w, int unsigned h, int unsigned c);
        drain();
        reg_write(REG_WIDTH, w);
        reg_write(REG_HEIGHT, h);
        reg_write(REG_COLOR, c);
    endtask

    task send_dot(logic [7:0] d);
        @(negedge clk);
        while ($urandom_range(99) < tx_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= d;
        do @(posedge clk); while (!s_axis_tready);
        sb.note_dot(d);
        last_dot = d;
    endtask

    task release_dot();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
    endtask

    function logic [7:0] pick_dot();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 30) return last_dot;
        if (r < 55) return tone_a;
        if (r < 75) return tone_b;
        return 8'($urandom_range(255));
    endfunction

    task run_image(int unsigned w, int unsigned h, int unsigned c);
        configure(w, h, c);
        tone_a = 8'($urandom_range(255));
        tone_b = 8'($urandom_range(255));
        last_dot = tone_a;
        for (int i = 0; i < w*h; i++) send_dot(pick_dot());
        release_dot();
    endtask

    initial
    begin
        int unsigned sent;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        configure(1, 1, 0);
        send_dot(8'hFF);
        send_dot(8'h00);
        send_dot(8'hA5);
        release_dot();
        configure(0, 0, 1);
        send_dot(8'hFF);
        send_dot(8'h80);
        send_dot(8'h01);
        release_dot();
        drain();
        reg_write(REG_HEIGHT, 32'h10000);
        configure(4, 3, 1);
        for (int i = 0; i < 12; i++) send_dot(8'(i < 6 ? 8'h5A : 8'hFF - i));
        release_dot();
        drain();

        for (int p = 0; p < 3; p++)
        begin
            tx_idle = (p == 0) ? 29 : (p == 1) ? 84 : 0;
            rx_idle = (p == 0) ? 84 : (p == 1) ? 29 : 0;
            sent = 0;
            if (p == 0)
            begin
                run_image(2, 18, 1);
                sent += 36;
            end
            while (sent < 40)
            begin
                int unsigned w, h;
                w = $urandom_range(1, 20);
                h = $urandom_range(1, 4);
                run_image(w, h, $urandom_range(1));
                sent += w * h;
                if (p == 1)
                begin
                    wait (sb.pending_words.size() == 0);
                    send_dot(pick_dot());
                    release_dot();
                    sent++;
                end
            end
        end

        drain();
        if (sb.errors == 0)
            $display("mag_image_encoder_core regression: pass");
        else
            $display("mag_image_encoder_core regression: fail");
        $finish;
    end

endmodule
